[rtl/lzwe_pkg.sv]
`default_nettype none
package lzwe_pkg;

    localparam int CODE_W  = 16;
    localparam int SLOT_W  = 17;
    localparam int SLOTS   = 1 << SLOT_W;
    localparam int EPOCH_W = 4;
    localparam int BYTE_W  = 8;
    localparam int KEY_W   = CODE_W + BYTE_W;
    localparam int SIZE_W  = CODE_W + 1;
    localparam int WIDTH_W = 5;
    localparam int ALPHA   = 256;
    localparam int ALPHA_W = 9;

    localparam logic [SLOT_W-1:0] HASH_MULT = 17'h179B1;

    localparam logic [1:0] OP_DECLARE = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // bit length of size+1, from the bit length of size
    function automatic logic [WIDTH_W-1:0] f_next_width(
        input logic [SIZE_W-1:0]  size,
        input logic [WIDTH_W-1:0] w
    );
        logic [SIZE_W:0] pw;
        pw = {{SIZE_W{1'b0}}, 1'b1} << w;
        if ({1'b0, size} + {{SIZE_W{1'b0}}, 1'b1} == pw) begin
            return w + 5'd1;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/lzwe_ram.sv]
`default_nettype none
module lzwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/lzw_encoder_variable_width.sv]
// LZW encoder, variable code width, declared alphabet.
// Input: command port. A beat is taken when start is high and busy is low:
//   i_operation 0 declares an alphabet byte, 1 encodes a data byte,
//   2 flushes the pending string.
// Output: o_valid strobes for one cycle with o_code, o_code_width, o_status.
//   The receiver cannot stall; every result is shown exactly once.
// Declare, flush and ignored operations leave busy low, and a flush result
// appears the cycle after the beat.
// A data byte that is rejected or starts a new string passes through S_SB only.
// One that needs a pair lookup goes on to S_RD and S_CMP and stays in S_CMP
// for each extra probe of the linear-probe hash table (131072 x 44 RAM, one
// read per cycle). A result, if any, appears as busy falls or as a clearing
// pass begins. Lookup and insert share the probe that ends on an empty slot.
// Table entries carry a 4-bit epoch. After reset, and on every 15th dictionary
// reset, a clearing pass writes all 131072 entries, one per cycle, with busy
// high; every other dictionary reset bumps the epoch instead of clearing.
`default_nettype none
module lzw_encoder_variable_width
    import lzwe_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          i_operation,
    input  wire logic [BYTE_W-1:0]   i_byte_value,
    output logic                     o_valid,
    output logic [CODE_W-1:0]        o_code,
    output logic [WIDTH_W-1:0]       o_code_width,
    output logic                     o_status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SB   = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_CLR  = 3'd4;

    logic [2:0]          r_state;
    logic [BYTE_W-1:0]   r_byte;
    logic [CODE_W-1:0]   r_pend;
    logic                r_pend_v;
    logic [ALPHA_W-1:0]  r_alpha;
    logic [WIDTH_W-1:0]  r_alpha_w;
    logic [SIZE_W-1:0]   r_size;
    logic [WIDTH_W-1:0]  r_width;
    logic [EPOCH_W-1:0]  r_epoch;
    logic [SLOT_W-1:0]   r_slot;
    logic [BYTE_W-1:0]   r_c;
    logic [ALPHA-1:0]    r_present;

    logic                sb_we;
    logic [BYTE_W-1:0]   sb_q;
    logic                tab_we;
    logic [SLOT_W-1:0]   tab_waddr;
    logic [SLOT_W-1:0]   tab_raddr;
    t_entry              tab_wdata;
    t_entry              tab_q;
    logic [KEY_W-1:0]    key;
    logic [SLOT_W-1:0]   slot_hash;
    logic                accept;
    logic                declare_ok;
    logic                hit;
    logic                empty;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && (r_state == S_IDLE);
    assign key       = {r_pend, r_byte};
    assign slot_hash = key[SLOT_W-1:0] * HASH_MULT;
    assign hit       = (tab_q.epoch == r_epoch) && (tab_q.key == key);
    assign empty     = (tab_q.epoch != r_epoch);
    assign declare_ok = !r_present[i_byte_value] && !r_pend_v
                        && (r_size == {{(SIZE_W-ALPHA_W){1'b0}}, r_alpha})
                        && !r_alpha[ALPHA_W-1];

    assign sb_we = accept && (i_operation == OP_DECLARE) && declare_ok;

    always_comb begin
        tab_we    = 1'b0;
        tab_waddr = r_slot;
        tab_wdata = '0;
        tab_raddr = r_slot;
        case (r_state)
            S_CMP: begin
                tab_raddr = r_slot + 17'd1;
                if (empty) begin
                    tab_we    = 1'b1;
                    tab_wdata = '{epoch: r_epoch, key: key, code: r_size[CODE_W-1:0]};
                end
            end
            S_CLR: begin
                tab_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    lzwe_ram #(.WIDTH(BYTE_W), .DEPTH(ALPHA)) u_sb_ram (
        .i_clk   (i_clk),
        .i_we    (sb_we),
        .i_waddr (i_byte_value),
        .i_wdata (r_alpha[BYTE_W-1:0]),
        .i_raddr (i_byte_value),
        .o_rdata (sb_q)
    );

    lzwe_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (tab_raddr),
        .o_rdata (tab_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_slot    <= '0;
            r_pend    <= '0;
            r_pend_v  <= 1'b0;
            r_alpha   <= '0;
            r_alpha_w <= '0;
            r_size    <= '0;
            r_width   <= '0;
            r_epoch   <= '0;
            r_present <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_byte <= i_byte_value;
                        case (i_operation)
                            OP_DECLARE: begin
                                if (declare_ok) begin
                                    r_present[i_byte_value] <= 1'b1;
                                    r_alpha   <= r_alpha + 9'd1;
                                    r_size    <= r_size + 17'd1;
                                    r_width   <= f_next_width(r_size, r_width);
                                    r_alpha_w <= f_next_width(r_size, r_width);
                                end
                            end
                            OP_FLUSH: begin
                                if (r_pend_v) begin
                                    o_valid      <= 1'b1;
                                    o_code       <= r_pend;
                                    o_code_width <= r_width;
                                    o_status     <= 1'b0;
                                    r_pend_v     <= 1'b0;
                                    r_pend       <= '0;
                                end
                            end
                            OP_DATA: begin
                                r_state <= S_SB;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SB: begin
                    if (!r_present[r_byte]) begin
                        o_valid      <= 1'b1;
                        o_code       <= '0;
                        o_code_width <= '0;
                        o_status     <= 1'b1;
                        r_state      <= S_IDLE;
                    end else if (!r_pend_v) begin
                        r_pend   <= {{(CODE_W-BYTE_W){1'b0}}, sb_q};
                        r_pend_v <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_c     <= sb_q;
                        r_slot  <= slot_hash;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (hit) begin
                        r_pend  <= tab_q.code;
                        r_state <= S_IDLE;
                    end else if (!empty) begin
                        r_slot <= r_slot + 17'd1;
                    end else begin
                        o_valid      <= 1'b1;
                        o_code       <= r_pend;
                        o_code_width <= r_width;
                        o_status     <= 1'b0;
                        r_pend       <= {{(CODE_W-BYTE_W){1'b0}}, r_c};
                        r_state      <= S_IDLE;
                        if (r_size[CODE_W-1:0] == {CODE_W{1'b1}}) begin
                            r_size  <= {{(SIZE_W-ALPHA_W){1'b0}}, r_alpha};
                            r_width <= r_alpha_w;
                            if (r_epoch == {EPOCH_W{1'b1}}) begin
                                r_slot  <= '0;
                                r_state <= S_CLR;
                            end else begin
                                r_epoch <= r_epoch + 4'd1;
                            end
                        end else begin
                            r_size  <= r_size + 17'd1;
                            r_width <= f_next_width(r_size, r_width);
                        end
                    end
                end
                S_CLR: begin
                    r_slot <= r_slot + 17'd1;
                    if (r_slot == {SLOT_W{1'b1}}) begin
                        r_epoch <= {{(EPOCH_W-1){1'b0}}, 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/lzwe_checker.sv]
`default_nettype none
module lzwe_checker
    import lzwe_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic [1:0]          i_operation,
    input wire logic                o_valid,
    input wire logic [CODE_W-1:0]   o_code,
    input wire logic [WIDTH_W-1:0]  o_code_width,
    input wire logic                o_status
);

    a_data_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_operation == OP_DATA |=> busy)
        else $error("data beat did not start a lookup");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_code == '0 && o_code_width == '0)
        else $error("reject beat carries a code");

    a_code_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_status |->
            o_code_width != '0 && (o_code >> o_code_width) == '0)
        else $error("code does not fit its width");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(busy) |-> $past(start) && $past(i_operation) == OP_FLUSH)
        else $error("result without a cause");

endmodule

bind lzw_encoder_variable_width lzwe_checker u_lzwe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_operation  (i_operation),
    .o_valid      (o_valid),
    .o_code       (o_code),
    .o_code_width (o_code_width),
    .o_status     (o_status)
);
`default_nettype wire
